// ===== sv/skya_pkg.sv =====
// skyline atlas allocator package
// shared control struct and request/status codes; no dependencies
package skya_pkg;

    // request operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic load;   // copy selected atlas heights into the window chain
        logic win;    // one window step: fold max, shift heights left
        logic scan;   // shift window maxima toward cell 0
        logic write;  // raise covered columns of the selected atlas
    } cell_ctl_t;

endpackage

// ===== sv/skya_cell.sv =====
// one skyline column: per-atlas height plus window and max chain stages
// depends on skya_pkg
module skya_cell #(
    parameter int NUM_ATLASES = 2,
    parameter int AW          = 1,
    parameter int HW          = 9,
    parameter int SW          = 10,
    parameter int INDEX       = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  skya_pkg::cell_ctl_t ctl,
    input  logic [AW-1:0]       atlas,
    input  logic [HW-1:0]       new_height,
    input  logic [SW-1:0]       lo,
    input  logic [SW-1:0]       hi,
    input  logic [HW-1:0]       s_in,
    input  logic [HW-1:0]       m_in,
    output logic [HW-1:0]       s_out,
    output logic [HW-1:0]       m_out
);
    import skya_pkg::*;

    logic [HW-1:0] height_reg [NUM_ATLASES];
    logic [HW-1:0] s_reg, s_next;
    logic [HW-1:0] m_reg, m_next;
    logic          in_range;

    assign in_range = (SW'(INDEX) >= lo) && (SW'(INDEX) < hi);

    always_comb
    begin
        s_next = s_reg;
        m_next = m_reg;
        if (ctl.load)
        begin
            s_next = height_reg[atlas];
            m_next = '0;
        end
        else if (ctl.win)
        begin
            s_next = s_in;
            m_next = (s_reg > m_reg) ? s_reg : m_reg;
        end
        else if (ctl.scan)
        begin
            m_next = m_in;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        m_reg <= m_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ATLASES; i++)
            begin
                height_reg[i] <= '0;
            end
        end
        else if (ctl.write && in_range)
        begin
            height_reg[atlas] <= new_height;
        end
    end

    assign s_out = s_reg;
    assign m_out = m_reg;

endmodule

// ===== sv/skyline_atlas_allocator_core.sv =====
// skyline atlas allocator top level: sequencer, column cell chain, result register
// depends on skya_pkg and skya_cell
//
// Bottom-left skyline packer over NUM_ATLASES atlases. Pulse start while busy
// is low to hand in one beat (func 0 allocate width_req x height_req, func 1
// flush atlas_sel). Every beat yields exactly one result beat, shown for a
// single cycle with done high; the receiver cannot stall, so sample it then.
// A flush or a zero-size allocate answers on the cycle after the start beat
// and leaves busy low. An allocate walks the atlases in order; for each atlas it
// loads the selected heights into the column chain, folds window maxima over
// width_req columns, scans the maxima out of cell 0 to find the lowest window,
// and then places the rectangle or moves on to the next atlas. All skyline
// heights and dirty marks clear at reset, no clearing pass needed.
module skyline_atlas_allocator_core #(
    parameter int NUM_ATLASES  = 2,
    parameter int ATLAS_WIDTH  = 256,
    parameter int ATLAS_HEIGHT = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       func,
    input  logic [8:0] width_req,
    input  logic [8:0] height_req,
    input  logic       atlas_sel,
    output logic       done,
    output logic       status,
    output logic       atlas_index,
    output logic [7:0] pos_x,
    output logic [7:0] pos_y,
    output logic       needs_upload
);
    import skya_pkg::*;

    // widths derived from the geometry
    localparam int AW   = (NUM_ATLASES > 1) ? $clog2(NUM_ATLASES) : 1;
    localparam int XW   = $clog2(ATLAS_WIDTH);
    localparam int HW   = $clog2(ATLAS_HEIGHT + 1);
    localparam int SW   = ((XW > 9) ? XW : 9) + 1;
    localparam int SUMW = ((HW > 9) ? HW : 9) + 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_WIN   = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_PLACE = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] atlas_reg, atlas_next;
    logic [8:0]    w_reg, w_next;
    logic [8:0]    h_reg, h_next;
    logic [8:0]    win_cnt_reg, win_cnt_next;
    logic [XW-1:0] x_reg, x_next;
    logic [XW-1:0] bx_reg, bx_next;
    logic [HW-1:0] best_reg, best_next;
    logic          dirty_reg [NUM_ATLASES];
    logic          dirty_next [NUM_ATLASES];

    // result register
    logic       done_reg, done_next;
    logic       status_reg, status_next;
    logic       index_reg, index_next;
    logic [7:0] pos_x_reg, pos_x_next;
    logic [7:0] pos_y_reg, pos_y_next;
    logic       upload_reg, upload_next;

    cell_ctl_t     ctl;
    logic [HW-1:0] s_link [ATLAS_WIDTH+1];
    logic [HW-1:0] m_link [ATLAS_WIDTH+1];
    logic [SUMW-1:0] top_sum;
    logic            fits;
    logic [SW-1:0]   lo, hi;
    logic            accept;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);

    // placement arithmetic on the winning window
    assign top_sum = SUMW'(best_reg) + SUMW'(h_reg);
    assign fits    = top_sum <= SUMW'(ATLAS_HEIGHT);
    assign lo      = SW'(bx_reg);
    assign hi      = SW'(bx_reg) + SW'(w_reg);

    // sentinel past the right edge: a full-height column never wins
    assign s_link[ATLAS_WIDTH] = HW'(ATLAS_HEIGHT);
    assign m_link[ATLAS_WIDTH] = HW'(ATLAS_HEIGHT);

    always_comb
    begin
        ctl.load  = (state_reg == ST_LOAD);
        ctl.win   = (state_reg == ST_WIN);
        ctl.scan  = (state_reg == ST_SCAN);
        ctl.write = (state_reg == ST_PLACE) && fits;
    end

    // one cell per column
    for (genvar g = 0; g < ATLAS_WIDTH; g++)
    begin : g_col
        skya_cell #(
            .NUM_ATLASES (NUM_ATLASES),
            .AW          (AW),
            .HW          (HW),
            .SW          (SW),
            .INDEX       (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .atlas      (atlas_reg),
            .new_height (HW'(top_sum)),
            .lo         (lo),
            .hi         (hi),
            .s_in       (s_link[g+1]),
            .m_in       (m_link[g+1]),
            .s_out      (s_link[g]),
            .m_out      (m_link[g])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        atlas_next   = atlas_reg;
        w_next       = w_reg;
        h_next       = h_reg;
        win_cnt_next = win_cnt_reg;
        x_next       = x_reg;
        bx_next      = bx_reg;
        best_next    = best_reg;
        for (int i = 0; i < NUM_ATLASES; i++)
        begin
            dirty_next[i] = dirty_reg[i];
        end
        done_next   = 1'b0;
        status_next = status_reg;
        index_next  = index_reg;
        pos_x_next  = pos_x_reg;
        pos_y_next  = pos_y_reg;
        upload_next = upload_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    w_next     = width_req;
                    h_next     = height_req;
                    atlas_next = '0;
                    if (func == FUNC_FLUSH)
                    begin
                        // flush: report and clear the mark
                        done_next   = 1'b1;
                        status_next = STATUS_OK;
                        index_next  = atlas_sel;
                        pos_x_next  = '0;
                        pos_y_next  = '0;
                        upload_next = 1'b0;
                        for (int i = 0; i < NUM_ATLASES; i++)
                        begin
                            if (32'(atlas_sel) == i)
                            begin
                                upload_next   = dirty_reg[i];
                                dirty_next[i] = 1'b0;
                            end
                        end
                    end
                    else if (width_req == '0 || height_req == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_FULL;
                        index_next  = 1'b0;
                        pos_x_next  = '0;
                        pos_y_next  = '0;
                        upload_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                win_cnt_next = w_reg;
                state_next   = ST_WIN;
            end
            ST_WIN:
            begin
                win_cnt_next = win_cnt_reg - 9'd1;
                if (win_cnt_reg == 9'd1)
                begin
                    x_next     = '0;
                    bx_next    = '0;
                    best_next  = HW'(ATLAS_HEIGHT);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // leftmost strictly lowest window wins
                if (m_link[0] < best_reg)
                begin
                    best_next = m_link[0];
                    bx_next   = x_reg;
                end
                x_next = x_reg + XW'(1);
                if (x_reg == XW'(ATLAS_WIDTH - 1))
                begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE:
            begin
                if (fits)
                begin
                    for (int i = 0; i < NUM_ATLASES; i++)
                    begin
                        if (AW'(i) == atlas_reg)
                        begin
                            dirty_next[i] = 1'b1;
                        end
                    end
                    done_next   = 1'b1;
                    status_next = STATUS_OK;
                    index_next  = atlas_reg[0];
                    pos_x_next  = 8'(bx_reg);
                    pos_y_next  = 8'(best_reg);
                    upload_next = 1'b0;
                    state_next  = ST_IDLE;
                end
                else if (atlas_reg == AW'(NUM_ATLASES - 1))
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_FULL;
                    index_next  = 1'b0;
                    pos_x_next  = '0;
                    pos_y_next  = '0;
                    upload_next = 1'b0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    atlas_next = atlas_reg + AW'(1);
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            for (int i = 0; i < NUM_ATLASES; i++)
            begin
                dirty_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            for (int i = 0; i < NUM_ATLASES; i++)
            begin
                dirty_reg[i] <= dirty_next[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        atlas_reg   <= atlas_next;
        w_reg       <= w_next;
        h_reg       <= h_next;
        win_cnt_reg <= win_cnt_next;
        x_reg       <= x_next;
        bx_reg      <= bx_next;
        best_reg    <= best_next;
        status_reg  <= status_next;
        index_reg   <= index_next;
        pos_x_reg   <= pos_x_next;
        pos_y_reg   <= pos_y_next;
        upload_reg  <= upload_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign atlas_index  = index_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign needs_upload = upload_reg;

endmodule

// ===== sv/skya_checker.sv =====
// port-level checks for the skyline atlas allocator
// depends on skyline_atlas_allocator_core ports only; bound below
module skya_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       status,
    input logic       atlas_index,
    input logic [7:0] pos_x,
    input logic [7:0] pos_y,
    input logic       needs_upload
);

    // an accepted beat is either still at work or answered next cycle
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat neither busy nor answered");

    // a full status carries no placement
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (pos_x == 8'd0 && pos_y == 8'd0 &&
                              atlas_index == 1'b0 && needs_upload == 1'b0))
        else $error("full status with nonzero fields");

    // an upload flag only comes with success
    a_upload_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && needs_upload) |-> !status)
        else $error("upload flag with full status");

    // a long search ends with its result beat
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result beat");

endmodule

bind skyline_atlas_allocator_core skya_checker u_skya_checker (.*);

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for skyline_atlas_allocator_core: directed and random allocate/flush beats
// predicts placements with its own skyline copy; depends on the core only

module tb_top;

    localparam int NATL   = 2;
    localparam int AW     = 256;
    localparam int AH     = 256;
    localparam bit OP_ALLOC = 1'b0;
    localparam bit OP_FLUSH = 1'b1;
    localparam bit STAT_FULL = 1'b1;

    typedef struct packed {
        logic       status;
        logic       atlas_index;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic       needs_upload;
    } placement_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       func = 1'b0;
    logic [8:0] width_req = 9'd1;
    logic [8:0] height_req = 9'd1;
    logic       atlas_sel = 1'b0;
    logic       busy, done, status, atlas_index, needs_upload;
    logic [7:0] pos_x, pos_y;

    // predictor state: skyline per atlas and column, dirty marks
    int unsigned skyline [NATL][AW];
    bit          dirty [NATL];
    placement_t  pending_placements [$];
    int          errors = 0;
    int          gap_pct = 0;

    always #5 clk = ~clk;

    skyline_atlas_allocator_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .width_req(width_req), .height_req(height_req),
        .atlas_sel(atlas_sel), .done(done), .status(status),
        .atlas_index(atlas_index), .pos_x(pos_x), .pos_y(pos_y),
        .needs_upload(needs_upload)
    );

    // bottom-left search of one atlas; raises columns on success
    function automatic bit fit_in_atlas(int a, int w, int h, output int px, output int py);
        int best;
        int bx;
        int top;
        bit ok;
        best = AH;
        bx = 0;
        px = 0;
        py = 0;
        if (w == 0 || w > AW)
            return 0;
        for (int i = 0; i + w <= AW; i++)
        begin
            top = 0;
            ok = 1;
            for (int j = 0; j < w; j++)
            begin
                if (skyline[a][i+j] >= best)
                begin
                    ok = 0;
                    break;
                end
                if (skyline[a][i+j] > top)
                    top = skyline[a][i+j];
            end
            if (ok)
            begin
                best = top;
                bx = i;
            end
        end
        if (best + h > AH)
            return 0;
        for (int j = 0; j < w; j++)
            skyline[a][bx+j] = best + h;
        px = bx;
        py = best;
        return 1;
    endfunction

    function automatic placement_t predict_placement(bit f, int w, int h, bit sel);
        placement_t r;
        int px;
        int py;
        r = '0;
        if (f == OP_FLUSH)
        begin
            r.atlas_index = sel;
            r.needs_upload = dirty[sel];
            dirty[sel] = 0;
            return r;
        end
        if (w != 0 && h != 0)
            for (int a = 0; a < NATL; a++)
                if (fit_in_atlas(a, w, h, px, py))
                begin
                    dirty[a] = 1;
                    r.atlas_index = a[0];
                    r.pos_x = px[7:0];
                    r.pos_y = py[7:0];
                    return r;
                end
        r.status = STAT_FULL;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker: done marks a one-cycle result beat
    always @(posedge clk)
    begin
        placement_t e;
        if (rst_n && done)
        begin
            if (pending_placements.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                e = pending_placements.pop_front();
                if (status !== e.status) report_mismatch("status", status, e.status);
                if (atlas_index !== e.atlas_index)
                    report_mismatch("atlas_index", atlas_index, e.atlas_index);
                if (pos_x !== e.pos_x) report_mismatch("pos_x", pos_x, e.pos_x);
                if (pos_y !== e.pos_y) report_mismatch("pos_y", pos_y, e.pos_y);
                if (needs_upload !== e.needs_upload)
                    report_mismatch("needs_upload", needs_upload, e.needs_upload);
            end
        end
    end

    // sends one beat, with random idle cycles before it
    task automatic send_beat(bit f, int w, int h, bit sel);
        while ($urandom_range(99) < gap_pct)
            @(posedge clk);
        func <= f;
        width_req <= w[8:0];
        height_req <= h[8:0];
        atlas_sel <= sel;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_placements.push_back(predict_placement(f, w, h, sel));
        start <= 1'b0;
        // hold start low before the next beat; a flush or zero-size answer never raises busy
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_placements.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_directed();
        send_beat(OP_FLUSH, 1, 1, 0);
        send_beat(OP_ALLOC, 0, 5, 0);
        send_beat(OP_ALLOC, 5, 0, 1);
        send_beat(OP_ALLOC, 257, 4, 0);
        send_beat(OP_ALLOC, 4, 257, 0);
        send_beat(OP_ALLOC, 511, 511, 1);
        send_beat(OP_ALLOC, 1, 1, 0);
        send_beat(OP_ALLOC, 256, 10, 0);
        send_beat(OP_ALLOC, 3, 256, 0);
        send_beat(OP_FLUSH, 0, 0, 0);
        send_beat(OP_FLUSH, 0, 0, 0);
        send_beat(OP_ALLOC, 256, 246, 0);
        send_beat(OP_ALLOC, 256, 256, 0);
        send_beat(OP_ALLOC, 200, 100, 0);
        send_beat(OP_FLUSH, 0, 0, 1);
        send_beat(OP_FLUSH, 0, 0, 1);
        send_beat(OP_ALLOC, 256, 200, 0);
        send_beat(OP_ALLOC, 256, 1, 0);
        drain_results();
    endtask

    // flushes both atlases, clearing their dirty marks
    task automatic rst_hold_free();
        send_beat(OP_FLUSH, 0, 0, 0);
        send_beat(OP_FLUSH, 0, 0, 1);
    endtask

    // mostly small rectangles to build a ragged skyline, a few big and odd ones
    task automatic test_random(int count, int gap);
        int w;
        int h;
        int k;
        gap_pct = gap;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(99);
            if (k < 12)
                send_beat(OP_FLUSH, $urandom_range(511), $urandom_range(511), $urandom_range(1));
            else
            begin
                if (k < 80)
                begin
                    w = $urandom_range(1, 24);
                    h = $urandom_range(1, 40);
                end
                else if (k < 95)
                begin
                    w = $urandom_range(1, 256);
                    h = $urandom_range(1, 256);
                end
                else
                begin
                    w = $urandom_range(511);
                    h = $urandom_range(511);
                end
                send_beat(OP_ALLOC, w, h, $urandom_range(1));
            end
            // now and then drain the results and flush both atlases
            if (n % 60 == 59)
            begin
                drain_results();
                rst_hold_free();
            end
        end
        drain_results();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(190, 14);
        test_random(190, 83);
        test_random(190, 0);
        drain_results();
        repeat (2100) @(posedge clk);
        if (errors == 0 && pending_placements.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
